### rtl/core/ilte_pkg.sv
// Package for the indexed list table engine: operation and status codes,
// sequencer states and the result record passed to the output register.
// No dependencies.
`default_nettype none

package ilte_pkg;

   localparam int OP_WIDTH    = 32;
   localparam int COUNT_WIDTH = 7;

   typedef enum logic [2:0] {
      MODE_APPEND   = 3'd0,
      MODE_INSERT   = 3'd1,
      MODE_REMOVE   = 3'd2,
      MODE_READ     = 3'd3,
      MODE_FIND     = 3'd4,
      MODE_SWAP_IDX = 3'd5,
      MODE_SWAP_VAL = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_RANGE   = 2'd1,
      ST_MISSING = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_WALK,
      S_SW_RA,
      S_SW_RB,
      S_SW_CAP,
      S_WR_X,
      S_WR_Y,
      S_DONE
   } state_type;

   typedef struct packed {
      status_type              status;
      logic [OP_WIDTH-1:0]     data;
      logic [COUNT_WIDTH-1:0]  count;
   } res_type;

endpackage

`default_nettype wire

### rtl/core/ilte_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module ilte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/core/ilte_rsp_reg.sv
// Result output register for the indexed list table engine.
// Depends on ilte_pkg.
`default_nettype none

module ilte_rsp_reg
   import ilte_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   res_vld,
   input  wire res_type                res,
   output logic                        res_free,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic        [1:0]           rsp_status,
   output logic signed [OP_WIDTH-1:0]  rsp_data,
   output logic        [COUNT_WIDTH-1:0] rsp_count
);

   logic    valid_ff;
   logic    valid_in;
   res_type res_ff;
   res_type res_in;

   assign res_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (res_vld && res_free) begin
         valid_in = 1'b1;
         res_in   = res;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_status = res_ff.status;
   assign rsp_data   = res_ff.data;
   assign rsp_count  = res_ff.count;

endmodule

`default_nettype wire

### rtl/core/ilte_seq.sv
// Operation sequencer: decodes one item, walks the entry memory for shifts
// and searches and for reads, and produces the result record. Depends on ilte_pkg.
`default_nettype none

module ilte_seq
   import ilte_pkg::*;
#(
   parameter int DEPTH      = 64,
   parameter int WORD_WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [2:0]               req_mode,
   input  wire logic [OP_WIDTH-1:0]      req_operand_a,
   input  wire logic [OP_WIDTH-1:0]      req_operand_b,
   output logic                          mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]      mem_wr_addr,
   output logic [WORD_WIDTH-1:0]         mem_wr_data,
   output logic                          mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]      mem_rd_addr,
   input  wire logic [WORD_WIDTH-1:0]    mem_rd_data,
   output logic                          res_vld,
   output res_type                       res,
   input  wire logic                     res_free
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   function automatic logic [WORD_WIDTH-1:0] to_word(input logic [OP_WIDTH-1:0] v);
      logic signed [OP_WIDTH-1:0] s;
      logic [63:0]                e;
      s = v;
      e = 64'(s);
      return e[WORD_WIDTH-1:0];
   endfunction

   function automatic logic [OP_WIDTH-1:0] to_op(input logic [WORD_WIDTH-1:0] w);
      logic signed [WORD_WIDTH-1:0] s;
      s = w;
      return OP_WIDTH'(s);
   endfunction

   state_type              state_ff, state_in;
   logic [2:0]             mode_ff, mode_in;
   logic [OP_WIDTH-1:0]    opa_ff, opa_in;
   logic [OP_WIDTH-1:0]    opb_ff, opb_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          ptr_ff, ptr_in;
   logic [AW-1:0]          end_ff, end_in;
   logic                   issue_ff, issue_in;
   logic                   dir_up_ff, dir_up_in;
   logic                   pend_ff, pend_in;
   logic [AW-1:0]          pend_addr_ff, pend_addr_in;
   logic                   pf_ff, pf_in;
   logic                   qf_ff, qf_in;
   logic [AW-1:0]          pidx_ff, pidx_in;
   logic [AW-1:0]          qidx_ff, qidx_in;
   logic [AW-1:0]          x_addr_ff, x_addr_in;
   logic [WORD_WIDTH-1:0]  x_data_ff, x_data_in;
   logic [AW-1:0]          y_addr_ff, y_addr_in;
   logic [WORD_WIDTH-1:0]  y_data_ff, y_data_in;
   status_type             status_ff, status_in;
   logic [OP_WIDTH-1:0]    data_ff, data_in;

   mode_type               mode_e;
   logic                   full;
   logic                   cnt_zero;
   logic                   a_lt_cnt;
   logic                   a_le_cnt;
   logic                   a_eq_cnt;
   logic                   b_lt_cnt;
   logic [AW-1:0]          a_idx;
   logic [AW-1:0]          b_idx;
   logic [AW-1:0]          cnt_last;
   logic [WORD_WIDTH-1:0]  word_a;
   logic [WORD_WIDTH-1:0]  word_b;
   logic                   pf_nx;
   logic                   qf_nx;
   logic [AW-1:0]          pidx_nx;
   logic [AW-1:0]          qidx_nx;
   logic                   both_found;
   logic                   walk_last;
   logic                   walk_done;

   assign mode_e   = mode_type'(mode_ff);
   assign full     = count_ff == CW'(DEPTH);
   assign cnt_zero = count_ff == '0;
   assign a_lt_cnt = !opa_ff[OP_WIDTH-1] && (opa_ff < OP_WIDTH'(count_ff));
   assign a_le_cnt = !opa_ff[OP_WIDTH-1] && (opa_ff <= OP_WIDTH'(count_ff));
   assign a_eq_cnt = opa_ff == OP_WIDTH'(count_ff);
   assign b_lt_cnt = !opb_ff[OP_WIDTH-1] && (opb_ff < OP_WIDTH'(count_ff));
   assign a_idx    = opa_ff[AW-1:0];
   assign b_idx    = opb_ff[AW-1:0];
   assign cnt_last = AW'(count_ff - CW'(1));
   assign word_a   = to_word(opa_ff);
   assign word_b   = to_word(opb_ff);

   // first-match tracking for both search values during a scan
   assign pf_nx      = pf_ff || (pend_ff && mem_rd_data == word_a);
   assign qf_nx      = qf_ff || (pend_ff && mem_rd_data == word_b);
   assign pidx_nx    = pf_ff ? pidx_ff : pend_addr_ff;
   assign qidx_nx    = qf_ff ? qidx_ff : pend_addr_ff;
   assign both_found = pf_nx && qf_nx;
   assign walk_last  = pend_ff && pend_addr_ff == end_ff;
   assign walk_done  = walk_last
                    || (mode_e == MODE_FIND && pf_nx)
                    || (mode_e == MODE_SWAP_VAL && both_found);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (mode_e)
               MODE_APPEND:   state_in = full ? S_DONE : S_WR_X;
               MODE_INSERT: begin
                  priority if (!a_le_cnt || full) begin
                     state_in = S_DONE;
                  end else if (a_eq_cnt) begin
                     state_in = S_WR_X;
                  end else begin
                     state_in = S_WALK;
                  end
               end
               MODE_REMOVE: begin
                  state_in = (!a_lt_cnt || a_idx == cnt_last) ? S_DONE : S_WALK;
               end
               MODE_READ:     state_in = a_lt_cnt ? S_WALK : S_DONE;
               MODE_FIND,
               MODE_SWAP_VAL: state_in = cnt_zero ? S_DONE : S_WALK;
               MODE_SWAP_IDX: state_in = (a_lt_cnt && b_lt_cnt) ? S_SW_RA : S_DONE;
               default:       state_in = S_DONE;
            endcase
         end
         S_WALK: begin
            if (walk_done) begin
               if (mode_e == MODE_INSERT || (mode_e == MODE_SWAP_VAL && both_found)) begin
                  state_in = S_WR_X;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SW_RA:  state_in = S_SW_RB;
         S_SW_RB:  state_in = S_SW_CAP;
         S_SW_CAP: state_in = S_WR_X;
         S_WR_X: begin
            if (mode_e == MODE_SWAP_IDX || mode_e == MODE_SWAP_VAL) begin
               state_in = S_WR_Y;
            end else begin
               state_in = S_DONE;
            end
         end
         S_WR_Y:   state_in = S_DONE;
         S_DONE: begin
            if (res_free) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      mode_in      = mode_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      end_in       = end_ff;
      issue_in     = issue_ff;
      dir_up_in    = dir_up_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      pf_in        = pf_ff;
      qf_in        = qf_ff;
      pidx_in      = pidx_ff;
      qidx_in      = qidx_ff;
      x_addr_in    = x_addr_ff;
      x_data_in    = x_data_ff;
      y_addr_in    = y_addr_ff;
      y_data_in    = y_data_ff;
      status_in    = status_ff;
      data_in      = data_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = x_addr_ff;
      mem_wr_data  = x_data_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = ptr_ff;
      req_stall    = state_ff != S_IDLE;
      res_vld      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in = req_mode;
               opa_in  = req_operand_a;
               opb_in  = req_operand_b;
            end
         end
         S_DECODE: begin
            status_in = ST_OK;
            data_in   = '0;
            pend_in   = 1'b0;
            issue_in  = 1'b1;
            pf_in     = 1'b0;
            qf_in     = 1'b0;
            dir_up_in = mode_e != MODE_INSERT;
            unique case (mode_e)
               MODE_APPEND: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end
                  x_addr_in = AW'(count_ff);
                  x_data_in = word_a;
               end
               MODE_INSERT: begin
                  priority if (!a_le_cnt) begin
                     status_in = ST_RANGE;
                  end else if (full) begin
                     status_in = ST_FULL;
                  end
                  x_addr_in = a_idx;
                  x_data_in = word_b;
                  ptr_in    = cnt_last;
                  end_in    = a_idx;
               end
               MODE_REMOVE: begin
                  if (!a_lt_cnt) begin
                     status_in = ST_RANGE;
                  end else if (a_idx == cnt_last) begin
                     count_in = count_ff - CW'(1);
                  end
                  ptr_in = a_idx + AW'(1);
                  end_in = cnt_last;
               end
               MODE_READ: begin
                  if (!a_lt_cnt) begin
                     status_in = ST_RANGE;
                  end
                  ptr_in = a_idx;
                  end_in = a_idx;
               end
               MODE_FIND,
               MODE_SWAP_VAL: begin
                  if (cnt_zero) begin
                     status_in = ST_MISSING;
                  end
                  ptr_in = '0;
                  end_in = cnt_last;
               end
               MODE_SWAP_IDX: begin
                  if (!(a_lt_cnt && b_lt_cnt)) begin
                     status_in = ST_RANGE;
                  end
                  x_addr_in = a_idx;
                  y_addr_in = b_idx;
               end
               default: begin
               end
            endcase
         end
         S_WALK: begin
            // reads run ahead of writes in the walk direction, so no
            // read ever sees an entry already rewritten by this item
            mem_rd_en    = issue_ff;
            mem_rd_addr  = ptr_ff;
            pend_in      = issue_ff;
            pend_addr_in = ptr_ff;
            if (issue_ff) begin
               if (ptr_ff == end_ff) begin
                  issue_in = 1'b0;
               end else begin
                  ptr_in = dir_up_ff ? ptr_ff + AW'(1) : ptr_ff - AW'(1);
               end
            end
            pf_in   = pf_nx;
            qf_in   = qf_nx;
            pidx_in = pidx_nx;
            qidx_in = qidx_nx;
            unique case (mode_e)
               MODE_INSERT: begin
                  mem_wr_en   = pend_ff;
                  mem_wr_addr = pend_addr_ff + AW'(1);
                  mem_wr_data = mem_rd_data;
               end
               MODE_REMOVE: begin
                  mem_wr_en   = pend_ff;
                  mem_wr_addr = pend_addr_ff - AW'(1);
                  mem_wr_data = mem_rd_data;
                  if (walk_last) begin
                     count_in = count_ff - CW'(1);
                  end
               end
               MODE_READ: begin
                  if (pend_ff) begin
                     data_in = to_op(mem_rd_data);
                  end
               end
               MODE_FIND: begin
                  if (walk_done) begin
                     if (pf_nx) begin
                        data_in = OP_WIDTH'(pidx_nx);
                     end else begin
                        status_in = ST_MISSING;
                     end
                  end
               end
               MODE_SWAP_VAL: begin
                  if (walk_done) begin
                     if (both_found) begin
                        x_addr_in = pidx_nx;
                        x_data_in = word_b;
                        y_addr_in = qidx_nx;
                        y_data_in = word_a;
                     end else begin
                        status_in = ST_MISSING;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         S_SW_RA: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = x_addr_ff;
         end
         S_SW_RB: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = y_addr_ff;
            y_data_in   = mem_rd_data;
         end
         S_SW_CAP: begin
            x_data_in = mem_rd_data;
         end
         S_WR_X: begin
            mem_wr_en = 1'b1;
            if (mode_e == MODE_APPEND || mode_e == MODE_INSERT) begin
               count_in = count_ff + CW'(1);
            end
         end
         S_WR_Y: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = y_addr_ff;
            mem_wr_data = y_data_ff;
         end
         S_DONE: begin
            res_vld = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign res.status = status_ff;
   assign res.data   = data_ff;
   assign res.count  = COUNT_WIDTH'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      mode_ff      <= mode_in;
      opa_ff       <= opa_in;
      opb_ff       <= opb_in;
      ptr_ff       <= ptr_in;
      end_ff       <= end_in;
      issue_ff     <= issue_in;
      dir_up_ff    <= dir_up_in;
      pend_ff      <= pend_in;
      pend_addr_ff <= pend_addr_in;
      pf_ff        <= pf_in;
      qf_ff        <= qf_in;
      pidx_ff      <= pidx_in;
      qidx_ff      <= qidx_in;
      x_addr_ff    <= x_addr_in;
      x_data_ff    <= x_data_in;
      y_addr_ff    <= y_addr_in;
      y_data_ff    <= y_data_in;
      status_ff    <= status_in;
      data_ff      <= data_in;
   end

endmodule

`default_nettype wire

### rtl/core/indexed_list_table_engine.sv
// Top level of the indexed list table engine.
// Depends on ilte_pkg, ilte_ram, ilte_seq and ilte_rsp_reg.
//
// Ordered list of signed words held in one DEPTH-entry RAM with a count of
// valid entries. One item is worked at a time: req_stall is high from the
// cycle after acceptance until the result is loaded into the output
// register, and the next item can enter while that result still waits.
// Insert and remove take longer with each entry shifted, find with each
// entry scanned up to the first match, and swap by value with each entry
// scanned, as the entry RAM has a single read and a single write port.
// Results come back in item order.
`default_nettype none

module indexed_list_table_engine
   import ilte_pkg::*;
#(
   parameter int DEPTH      = 64,
   parameter int WORD_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic        [2:0]             req_mode,
   input  wire logic signed [OP_WIDTH-1:0]    req_operand_a,
   input  wire logic signed [OP_WIDTH-1:0]    req_operand_b,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic             [1:0]             rsp_status,
   output logic signed      [OP_WIDTH-1:0]    rsp_data,
   output logic             [COUNT_WIDTH-1:0] rsp_count
);

   localparam int AW = $clog2(DEPTH);

   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [WORD_WIDTH-1:0] mem_wr_data;
   logic                  mem_rd_en;
   logic [AW-1:0]         mem_rd_addr;
   logic [WORD_WIDTH-1:0] mem_rd_data;
   logic                  res_vld;
   res_type               res;
   logic                  res_free;

   ilte_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   ilte_seq #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data),
      .res_vld       (res_vld),
      .res           (res),
      .res_free      (res_free)
   );

   ilte_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .res_vld    (res_vld),
      .res        (res),
      .res_free   (res_free),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_count  (rsp_count)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted but engine not busy next cycle");

   a_result_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared with no item in flight");

   a_error_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_data == '0)
      else $error("error result carries nonzero data");
`endif

endmodule

`default_nettype wire

### sim/ilte_result_checker.sv
// Result checker for the indexed list table engine: keeps its own copy of the list,
// predicts one result per accepted item and compares accepted results in order.
// Depends on ilte_pkg for the mode and status codes and the result record.
module ilte_result_checker
   import ilte_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic        [2:0]             req_mode,
   input  wire logic signed [OP_WIDTH-1:0]    req_operand_a,
   input  wire logic signed [OP_WIDTH-1:0]    req_operand_b,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic        [1:0]             rsp_status,
   input  wire logic signed [OP_WIDTH-1:0]    rsp_data,
   input  wire logic        [COUNT_WIDTH-1:0] rsp_count,
   output int                                 mismatch_count,
   output int                                 results_owed,
   output int                                 stored_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic signed [OP_WIDTH-1:0] list_mem [0:DEPTH-1];
   int                         list_len;
   res_type                    expected_results [$];

   initial begin
      mismatch_count = 0;
      results_owed   = 0;
      stored_count   = 0;
      list_len       = 0;
   end

   function automatic int first_pos(input logic signed [OP_WIDTH-1:0] v);
      for (int i = 0; i < list_len; i++) begin
         if (list_mem[i] == v) return i;
      end
      return -1;
   endfunction

   task automatic apply_list_op(input logic [2:0] m,
                                input logic signed [OP_WIDTH-1:0] a,
                                input logic signed [OP_WIDTH-1:0] b,
                                output res_type r);
      int p;
      int q;
      logic signed [OP_WIDTH-1:0] t;
      r.status = ST_OK;
      r.data   = '0;
      case (m)
         MODE_APPEND: begin
            if (list_len >= DEPTH) r.status = ST_FULL;
            else begin
               list_mem[list_len] = a;
               list_len++;
            end
         end
         MODE_INSERT: begin
            if (a < 0 || a > list_len) r.status = ST_RANGE;
            else if (list_len >= DEPTH) r.status = ST_FULL;
            else begin
               for (int i = list_len; i > a; i--) list_mem[i] = list_mem[i-1];
               list_mem[a] = b;
               list_len++;
            end
         end
         MODE_REMOVE: begin
            if (a < 0 || a >= list_len) r.status = ST_RANGE;
            else begin
               for (int i = a; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
               list_len--;
            end
         end
         MODE_READ: begin
            if (a < 0 || a >= list_len) r.status = ST_RANGE;
            else r.data = list_mem[a];
         end
         MODE_FIND: begin
            p = first_pos(a);
            if (p < 0) r.status = ST_MISSING;
            else r.data = p;
         end
         MODE_SWAP_IDX: begin
            if (a < 0 || a >= list_len || b < 0 || b >= list_len) r.status = ST_RANGE;
            else begin
               t           = list_mem[a];
               list_mem[a] = list_mem[b];
               list_mem[b] = t;
            end
         end
         MODE_SWAP_VAL: begin
            p = first_pos(a);
            q = first_pos(b);
            if (p < 0 || q < 0) r.status = ST_MISSING;
            else begin
               t           = list_mem[p];
               list_mem[p] = list_mem[q];
               list_mem[q] = t;
            end
         end
         default: ;
      endcase
      r.count = list_len[COUNT_WIDTH-1:0];
   endtask

   task automatic flag_mismatch(input string what, input res_type want, input res_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] %s: expected status=%0d data=%0d count=%0d, got status=%0d data=%0d count=%0d",
                  $realtime, what, want.status, $signed(want.data), want.count,
                  got.status, $signed(got.data), got.count);
   endtask

   always @(posedge clock) begin
      res_type want;
      res_type got;
      if (reset) begin
         list_len = 0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.status = status_type'(rsp_status);
            got.data   = rsp_data;
            got.count  = rsp_count;
            if (expected_results.size() == 0) begin
               want = '0;
               flag_mismatch("result with no item outstanding", want, got);
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status || got.data !== want.data ||
                   got.count !== want.count)
                  flag_mismatch("result mismatch", want, got);
            end
         end
         if (req_valid && !req_stall) begin
            apply_list_op(req_mode, req_operand_a, req_operand_b, want);
            expected_results.push_back(want);
         end
      end
      results_owed = expected_results.size();
      stored_count = list_len;
   end

endmodule

### sim/indexed_list_table_engine_tb.sv
// Testbench top for the indexed list table engine: clock, reset, item stimulus,
// receiver stall pattern and the final verdict.
// Depends on ilte_pkg, the engine RTL and ilte_result_checker.
module indexed_list_table_engine_tb;
   import ilte_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         DEPTH       = 64;
   localparam int         PHASE_ITEMS = 250;
   localparam int         HOLD_CYCLES = 300;
   localparam logic [2:0] MODE_UNUSED = 3'd7;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic        [2:0]             req_mode;
   logic signed [OP_WIDTH-1:0]    req_operand_a;
   logic signed [OP_WIDTH-1:0]    req_operand_b;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic        [1:0]             rsp_status;
   logic signed [OP_WIDTH-1:0]    rsp_data;
   logic        [COUNT_WIDTH-1:0] rsp_count;

   int   mismatch_count;
   int   results_owed;
   int   stored_count;

   int   stall_style;
   logic want_hold;
   int   hold_left;
   int   stall_tick;

   logic signed [OP_WIDTH-1:0] value_pool [8];

   always #5 clock = ~clock;

   indexed_list_table_engine #(.DEPTH(DEPTH), .WORD_WIDTH(32)) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_data      (rsp_data),
      .rsp_count     (rsp_count)
   );

   ilte_result_checker #(.DEPTH(DEPTH)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_operand_a  (req_operand_a),
      .req_operand_b  (req_operand_b),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_data       (rsp_data),
      .rsp_count      (rsp_count),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed),
      .stored_count   (stored_count)
   );

   // receiver stall pattern; a requested long hold is counted down here
   always @(negedge clock) begin
      if (want_hold) begin
         want_hold = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      stall_tick++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 25);
            2: rsp_stall <= ($urandom_range(0, 99) < 70);
            default: rsp_stall <= ((stall_tick % 5) < 2);
         endcase
      end
   end

   task automatic send_item(input logic [2:0] m,
                            input logic signed [OP_WIDTH-1:0] a,
                            input logic signed [OP_WIDTH-1:0] b);
      req_valid     <= 1'b1;
      req_mode      <= m;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic logic signed [OP_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2, 3: return $urandom;
         default: return value_pool[$urandom_range(0, 7)];
      endcase
   endfunction

   function automatic logic signed [OP_WIDTH-1:0] pick_index(input int limit);
      if (limit > 0 && $urandom_range(0, 99) < 88) return $urandom_range(0, limit - 1);
      case ($urandom_range(0, 3))
         0: return -1;
         1: return limit;
         2: return $urandom;
         default: return limit + 1;
      endcase
   endfunction

   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int cut [3][7];
      int kind_of [6];
      int kind;
      int sent;
      int burst;
      int gap;
      int r;
      int w;
      logic [2:0] m;
      logic signed [OP_WIDTH-1:0] a;
      logic signed [OP_WIDTH-1:0] b;

      cut           = '{'{40, 65, 72, 80, 87, 92, 98},
                        '{ 8, 15, 55, 67, 77, 85, 97},
                        '{20, 35, 55, 67, 79, 88, 98}};
      kind_of       = '{0, 1, 2, 0, 2, 1};
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_mode      = '0;
      req_operand_a = '0;
      req_operand_b = '0;
      rsp_stall     = 1'b0;
      stall_style   = 0;
      want_hold     = 1'b0;
      hold_left     = 0;
      stall_tick    = 0;

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty list, extremes, every operation and its range and missing error cases
      send_item(MODE_READ, 0, 0);
      send_item(MODE_REMOVE, 0, 0);
      send_item(MODE_FIND, 0, 0);
      send_item(MODE_SWAP_IDX, 0, 0);
      send_item(MODE_SWAP_VAL, 0, 0);
      send_item(MODE_APPEND, 32'sh7fffffff, 0);
      send_item(MODE_APPEND, 32'sh80000000, 32'sh7fffffff);
      send_item(MODE_APPEND, 0, -1);
      send_item(MODE_APPEND, -1, 0);
      send_item(MODE_INSERT, 0, 32'sh12345678);
      send_item(MODE_INSERT, 5, 32'sh80000001);
      send_item(MODE_INSERT, 7, 1);
      send_item(MODE_INSERT, -1, 2);
      send_item(MODE_READ, 0, -1);
      send_item(MODE_READ, 5, 0);
      send_item(MODE_READ, 6, 0);
      send_item(MODE_READ, 32'sh80000000, 0);
      send_item(MODE_FIND, -1, 0);
      send_item(MODE_SWAP_IDX, 0, 5);
      send_item(MODE_SWAP_IDX, 2, 2);
      send_item(MODE_SWAP_IDX, 1, 6);
      send_item(MODE_SWAP_IDX, -1, 0);
      send_item(MODE_SWAP_VAL, 32'sh7fffffff, -1);
      send_item(MODE_SWAP_VAL, 0, 0);
      send_item(MODE_SWAP_VAL, 0, 555);
      send_item(MODE_REMOVE, 0, 0);
      send_item(MODE_REMOVE, 4, 0);
      send_item(MODE_REMOVE, -1, 0);
      send_item(MODE_UNUSED, -1, -1);
      req_valid <= 1'b0;
      wait (results_owed == 0);
      @(negedge clock);

      for (int phase = 0; phase < 6; phase++) begin
         kind        = kind_of[phase];
         stall_style = phase % 4;
         value_pool[0] = 0;
         value_pool[1] = -1;
         for (int j = 2; j < 8; j++) value_pool[j] = $urandom;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
               r = $urandom_range(0, 99);
               m = MODE_UNUSED;
               for (int j = 6; j >= 0; j--) begin
                  if (r < cut[kind][j]) m = 3'(j);
               end
               case (m)
                  MODE_APPEND, MODE_FIND: begin
                     a = pick_value();
                     b = $urandom;
                  end
                  MODE_INSERT: begin
                     a = pick_index(stored_count + 1);
                     b = pick_value();
                  end
                  MODE_REMOVE, MODE_READ: begin
                     a = pick_index(stored_count);
                     b = $urandom;
                  end
                  MODE_SWAP_IDX: begin
                     a = pick_index(stored_count);
                     b = pick_index(stored_count);
                  end
                  MODE_SWAP_VAL: begin
                     a = pick_value();
                     b = pick_value();
                  end
                  default: begin
                     a = $urandom;
                     b = $urandom;
                  end
               endcase
               send_item(m, a, b);
               sent++;
               if (phase == 2 && sent == 100) want_hold = 1'b1;
            end
            gap = (phase % 3 == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         // drain before the next phase
         req_valid <= 1'b0;
         wait (results_owed == 0);
         @(negedge clock);
      end

      for (w = 0; w < 20000 && results_owed != 0; w++) @(posedge clock);
      repeat (80) @(posedge clock);
      if (mismatch_count == 0 && results_owed == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### indexed_list_table_engine.f
rtl/core/ilte_pkg.sv
rtl/core/ilte_ram.sv
rtl/core/ilte_rsp_reg.sv
rtl/core/ilte_seq.sv
rtl/core/indexed_list_table_engine.sv
sim/ilte_result_checker.sv
sim/indexed_list_table_engine_tb.sv
